/* hw/rtl/csvp_pkg.sv */
// shared types, constants and error codes of the csv signed integer row parser
// no dependencies
`default_nettype none

package csvp_pkg;

    // width of a parsed value, sign included
    localparam int VALUE_BITS  = 32;
    // default number of entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // characters the parser looks for
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_EARLY   = 2'd1;
    localparam logic [1:0] ERR_NONDIG  = 2'd2;
    localparam logic [1:0] ERR_BAD_SEP = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_last;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] field_value;
        logic                         is_label;
        logic [1:0]                   error_code;
        logic                         line_done;
    } t_result;

    // one queue entry: the first result in full, the second one (always an
    // error with value zero and line_done set) by its code and label only
    typedef struct packed {
        t_result    first;
        logic       has_second;
        logic [1:0] second_err;
        logic       second_label;
    } t_cmd;

endpackage

`default_nettype wire

/* hw/rtl/csvp_front.sv */
// front part: takes text beats, keeps the per-line parse state and
// turns each beat into at most one queue entry; uses csvp_pkg
`default_nettype none

module csvp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire csvp_pkg::t_item i_in_item,
    input  wire logic          i_queue_full,
    output logic               o_accept,
    output logic               o_push,
    output csvp_pkg::t_cmd     o_cmd
);
    import csvp_pkg::*;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_DIGITS = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    localparam int VB = VALUE_BITS;
    localparam logic [VB-2:0] MAG_MAX = '1;

    logic [1:0]    r_mode, n_mode;
    logic          r_neg, n_neg;
    logic [VB-2:0] r_mag, n_mag;
    logic          r_first, n_first;

    logic          is_digit;
    logic [3:0]    digit;
    logic [VB+2:0] ext;
    logic [VB-2:0] mag_acc;
    logic [VB-2:0] mag_val;
    logic [VB-1:0] pos_val;
    logic [VB-1:0] sgn_val;
    logic          emit;
    t_cmd          cmd;
    logic [7:0]    b;
    logic          last;

    assign b    = i_in_item.text_byte;
    assign last = i_in_item.line_last;

    // '0'..'9' carry their digit in the low nibble
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = b[3:0];

    // acc*10 + d with saturation at the largest magnitude
    assign ext = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
               + {{(VB-1){1'b0}}, digit};
    assign mag_acc = (ext > {4'b0, MAG_MAX}) ? MAG_MAX : ext[VB-2:0];

    // magnitude shown with the value: the updated one on a digit
    always_comb begin
        if (!is_digit) begin
            mag_val = r_mag;
        end else if (r_mode == MODE_START) begin
            mag_val = {{(VB-5){1'b0}}, digit};
        end else begin
            mag_val = mag_acc;
        end
    end

    assign pos_val = {1'b0, mag_val};
    assign sgn_val = r_neg ? ((~pos_val) + {{(VB-1){1'b0}}, 1'b1}) : pos_val;

    always_comb begin
        n_mode  = r_mode;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_first = r_first;
        emit    = 1'b0;
        cmd     = '0;
        cmd.first.is_label = r_first;
        cmd.second_label   = r_first;

        unique case (r_mode)
            MODE_START: begin
                if (b == CH_MINUS) begin
                    n_neg = !r_neg;
                    if (last) begin
                        emit = 1'b1;
                        cmd.first.error_code = ERR_EARLY;
                        cmd.first.line_done  = 1'b1;
                    end
                end else if (is_digit) begin
                    n_mag  = mag_val;
                    n_mode = MODE_DIGITS;
                    if (last) begin
                        emit = 1'b1;
                        cmd.first.field_value = sgn_val;
                        cmd.first.line_done   = 1'b1;
                    end
                end else begin
                    emit = 1'b1;
                    cmd.first.error_code = ERR_NONDIG;
                    cmd.first.line_done  = 1'b1;
                    n_mode = MODE_SKIP;
                end
            end
            MODE_DIGITS: begin
                if (is_digit) begin
                    n_mag = mag_val;
                    if (last) begin
                        emit = 1'b1;
                        cmd.first.field_value = sgn_val;
                        cmd.first.line_done   = 1'b1;
                    end
                end else if (b == CH_COMMA) begin
                    emit = 1'b1;
                    cmd.first.field_value = sgn_val;
                    n_first = 1'b0;
                    n_neg   = 1'b0;
                    n_mag   = '0;
                    n_mode  = MODE_START;
                    if (last) begin
                        // line ends right after the comma
                        cmd.has_second   = 1'b1;
                        cmd.second_err   = ERR_EARLY;
                        cmd.second_label = 1'b0;
                    end
                end else if (b == CH_LF || b == CH_CR) begin
                    emit = 1'b1;
                    cmd.first.field_value = sgn_val;
                    cmd.first.line_done   = 1'b1;
                    n_mode = MODE_SKIP;
                end else begin
                    emit = 1'b1;
                    cmd.first.field_value = sgn_val;
                    cmd.has_second = 1'b1;
                    cmd.second_err = ERR_BAD_SEP;
                    n_mode = MODE_SKIP;
                end
            end
            default: begin
                // skipping to the end of the line
            end
        endcase

        if (last) begin
            n_mode  = MODE_START;
            n_neg   = 1'b0;
            n_mag   = '0;
            n_first = 1'b1;
        end
    end

    assign o_accept = i_in_valid && !i_queue_full;
    assign o_push   = o_accept && emit;
    assign o_cmd    = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_START;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_first <= 1'b1;
        end else if (o_accept) begin
            r_mode  <= n_mode;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/csvp_queue.sv */
// short command queue between the front and the back part; uses csvp_pkg
`default_nettype none

module csvp_queue #(
    parameter int DEPTH = csvp_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire csvp_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output csvp_pkg::t_cmd      o_head
);
    import csvp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_FULL);
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_entry[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/csvp_back.sv */
// back part: unpacks queue entries into one or two result beats held in
// an output register; uses csvp_pkg
`default_nettype none

module csvp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_nonempty,
    input  wire csvp_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output csvp_pkg::t_result   o_out_item,
    input  wire logic           i_out_stall
);
    import csvp_pkg::*;

    logic    r_valid;
    t_result r_out;
    logic    r_pend;
    logic    r_pend_label;
    logic [1:0] r_pend_err;
    logic    load;

    // output register free or being emptied this cycle
    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !r_pend && i_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_nonempty;
                r_pend  <= i_nonempty && i_head.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_out.field_value <= '0;
                r_out.is_label    <= r_pend_label;
                r_out.error_code  <= r_pend_err;
                r_out.line_done   <= 1'b1;
            end else if (i_nonempty) begin
                r_out        <= i_head.first;
                r_pend_err   <= i_head.second_err;
                r_pend_label <= i_head.second_label;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/csv_signed_integer_row_parser_unit.sv */
// top level of the csv signed integer row parser
// instantiates csvp_front, csvp_queue and csvp_back; uses csvp_pkg
//
// usage
// - input channel: one text byte per beat (i_in_valid / o_in_stall), with
//   line_last set on the final byte of each line
// - output channel: one parsed field or error per beat (o_out_valid /
//   i_out_stall); line_done marks the last result of a line
// - a byte's first result is written into a queue entry when the byte is
//   accepted and then loaded into the output register once the output is
//   free, where the receiver can take it
// - the input takes one byte every cycle while the queue is not full; a byte
//   yields zero, one or two results, and the output register sends one result
//   per cycle while not stalled, so a byte with two results (comma on the last
//   byte, bad separator) holds the back part until both are sent
// - the front part parses into a queue of QUEUE_DEPTH entries; o_in_stall
//   rises only when that queue is full, i.e. when the receiver has stalled
//   the output or two-result bytes have built up a backlog
// - a stalled result holds steady on o_out_item until taken
// - reset (synchronous, active low) empties the queue and the output
//   register and returns the parser to the start of a line, label expected
`default_nettype none

module csv_signed_integer_row_parser_unit #(
    parameter int QUEUE_DEPTH = csvp_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire csvp_pkg::t_item i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output csvp_pkg::t_result    o_out_item,
    input  wire logic            i_out_stall
);
    import csvp_pkg::*;

    // front to queue
    logic accept;
    logic push;
    t_cmd push_cmd;

    // queue status and head
    logic q_full;
    logic q_nonempty;
    t_cmd q_head;
    logic pop;

    csvp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (q_full),
        .o_accept     (accept),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    csvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    csvp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // the input stalls only on a full queue
    assign o_in_stall = q_full;

    // an entry is only pushed on an accepted byte
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> accept)
        else $error("queue push without an accepted byte");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.error_code != ERR_NONE)
            |-> (o_out_item.field_value == '0))
        else $error("error result with a non-zero value");

    // every error closes its line
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.error_code != ERR_NONE)
            |-> o_out_item.line_done)
        else $error("error result without line_done");

    // nothing is shown right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire
